@@ rtl/sap_pkg.sv @@
// Shared widths, register codes, word types and saturation for the spring projection block.
package sap_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int LANES         = 3;
    localparam int CFG_BITS      = 31;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_REST   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STIFF  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT = 2'd2;

    localparam logic [CFG_BITS-1:0] CFG_ONE = CFG_BITS'(1) << FRAC_BITS;

    localparam int SUM_BITS  = WORD_BITS + 1;
    localparam int MAG_BITS  = WORD_BITS;
    localparam int SQ_BITS   = 2 * WORD_BITS;
    localparam int ROOT_BITS = WORD_BITS;
    localparam int NUM1_BITS = CFG_BITS + MAG_BITS;
    localparam int Q1_BITS   = WORD_BITS;
    localparam int ABSD_BITS = WORD_BITS + 1;
    localparam int PROD_BITS = CFG_BITS + ABSD_BITS;
    localparam int DEN_BITS  = 2 * CFG_BITS + 1;
    localparam int Q2_BITS   = WORD_BITS + 2;
    localparam int Z_BITS    = Q2_BITS + 2;

    localparam int LATENCY = 3 + ROOT_BITS + 1 + Q1_BITS + 2 + Q2_BITS + 2;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] dix_x;
        logic signed [WORD_BITS-1:0] dix_y;
        logic signed [WORD_BITS-1:0] dix_z;
        logic signed [WORD_BITS-1:0] dual_x;
        logic signed [WORD_BITS-1:0] dual_y;
        logic signed [WORD_BITS-1:0] dual_z;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] proj_x;
        logic signed [WORD_BITS-1:0] proj_y;
        logic signed [WORD_BITS-1:0] proj_z;
        logic signed [WORD_BITS-1:0] new_dual_x;
        logic signed [WORD_BITS-1:0] new_dual_y;
        logic signed [WORD_BITS-1:0] new_dual_z;
    } t_out_word;

    typedef struct packed {
        logic               big;
        logic [SQ_BITS-1:0] sq;
    } t_lane_stat;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [Z_BITS-1:0] v
    );
        logic signed [WORD_BITS-1:0] res;
        if ((&v[Z_BITS-1:WORD_BITS-1]) || !(|v[Z_BITS-1:WORD_BITS-1])) begin
            res = v[WORD_BITS-1:0];
        end else if (v[Z_BITS-1]) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/sap_delay.sv @@
// Enabled shift line that delays a word by a fixed number of stages.
module sap_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

@@ rtl/sap_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module sap_div_pipe #(
    parameter int QBITS = 32,
    parameter int DBITS = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DBITS-1:0] i_rem,
    input  logic [QBITS-1:0] i_low,
    input  logic [DBITS-1:0] i_den,
    output logic [QBITS-1:0] o_quo,
    output logic [DBITS-1:0] o_rem
);
    logic [DBITS-1:0] w_rem [QBITS+1];
    logic [DBITS-1:0] w_den [QBITS+1];
    logic [QBITS-1:0] w_x   [QBITS+1];

    assign w_rem[0] = i_rem;
    assign w_den[0] = i_den;
    assign w_x[0]   = i_low;

    for (genvar g = 0; g < QBITS; g++) begin : g_stage
        logic [DBITS:0]   w_trial;
        logic             w_hit;
        logic [DBITS-1:0] r_rem;
        logic [DBITS-1:0] r_den;
        logic [QBITS-1:0] r_x;

        assign w_trial = {w_rem[g], w_x[g][QBITS-1]};
        assign w_hit   = w_trial >= {1'b0, w_den[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_hit ? DBITS'(w_trial - {1'b0, w_den[g]}) : w_trial[DBITS-1:0];
                r_den <= w_den[g];
                r_x   <= {w_x[g][QBITS-2:0], w_hit};
            end
        end

        assign w_rem[g+1] = r_rem;
        assign w_den[g+1] = r_den;
        assign w_x[g+1]   = r_x;
    end

    assign o_quo = w_x[QBITS];
    assign o_rem = w_rem[QBITS];
endmodule

@@ rtl/sap_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
module sap_sqrt_pipe #(
    parameter int RBITS = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [2*RBITS-1:0] i_val,
    output logic [RBITS-1:0]   o_root
);
    logic [2*RBITS-1:0] w_val  [RBITS+1];
    logic [RBITS+1:0]   w_rem  [RBITS+1];
    logic [RBITS-1:0]   w_root [RBITS+1];

    assign w_val[0]  = i_val;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < RBITS; g++) begin : g_stage
        logic [RBITS+3:0]   w_cand;
        logic [RBITS+3:0]   w_trial;
        logic               w_hit;
        logic [2*RBITS-1:0] r_val;
        logic [RBITS+1:0]   r_rem;
        logic [RBITS-1:0]   r_root;

        assign w_cand  = {w_rem[g], w_val[g][2*RBITS-1:2*RBITS-2]};
        assign w_trial = {2'b00, w_root[g], 2'b01};
        assign w_hit   = w_cand >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val  <= {w_val[g][2*RBITS-3:0], 2'b00};
                r_rem  <= w_hit ? (RBITS+2)'(w_cand - w_trial) : (RBITS+2)'(w_cand);
                r_root <= {w_root[g][RBITS-2:0], w_hit};
            end
        end

        assign w_val[g+1]  = r_val;
        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
    end

    assign o_root = w_root[RBITS];
endmodule

@@ rtl/sap_lane.sv @@
// One vector component: sum, magnitude, sphere projection, blend and dual update.
module sap_lane (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [sap_pkg::WORD_BITS-1:0]  i_dix,
    input  logic signed [sap_pkg::WORD_BITS-1:0]  i_dual,
    input  logic                                  i_sh,
    input  logic        [sap_pkg::ROOT_BITS-1:0]  i_root,
    input  logic        [sap_pkg::CFG_BITS-1:0]   i_rest,
    input  logic        [sap_pkg::CFG_BITS-1:0]   i_stiff,
    input  logic        [sap_pkg::DEN_BITS-1:0]   i_den,
    output sap_pkg::t_lane_stat                   o_stat,
    output logic signed [sap_pkg::WORD_BITS-1:0]  o_proj,
    output logic signed [sap_pkg::WORD_BITS-1:0]  o_new_dual
);
    import sap_pkg::*;

    logic signed [SUM_BITS-1:0]   w_sum;
    logic signed [SUM_BITS-1:0]   r_s1;
    logic        [SUM_BITS-1:0]   r_mag1;
    logic        [MAG_BITS-1:0]   w_m;
    logic signed [SUM_BITS-1:0]   r_s2;
    logic        [MAG_BITS-1:0]   r_m2;
    logic        [SQ_BITS-1:0]    r_sq2;
    logic signed [SUM_BITS-1:0]   w_s35;
    logic        [MAG_BITS-1:0]   w_m35;
    logic        [NUM1_BITS-1:0]  r_num;
    logic        [ROOT_BITS-1:0]  r_n36;
    logic signed [SUM_BITS-1:0]   r_s36;
    logic        [Q1_BITS-1:0]    w_q1;
    logic signed [SUM_BITS-1:0]   w_s68;
    logic                         w_nz68;
    logic        [Q1_BITS-1:0]    w_pm;
    logic signed [ABSD_BITS:0]    w_p;
    logic signed [ABSD_BITS:0]    w_diff;
    logic        [ABSD_BITS-1:0]  r_absd;
    logic                         r_dneg69;
    logic signed [SUM_BITS-1:0]   r_s69;
    logic        [PROD_BITS-1:0]  r_prod;
    logic                         r_dneg70;
    logic signed [SUM_BITS-1:0]   r_s70;
    logic        [Q2_BITS-1:0]    w_q2;
    logic        [DEN_BITS-1:0]   w_rem2;
    logic signed [SUM_BITS-1:0]   w_s104;
    logic                         w_dneg104;
    logic                         w_up;
    logic        [Q2_BITS:0]      w_q;
    logic signed [Z_BITS-1:0]     w_z;
    logic signed [WORD_BITS-1:0]  r_z105;
    logic signed [SUM_BITS-1:0]   r_s105;
    logic signed [WORD_BITS-1:0]  r_z106;
    logic signed [WORD_BITS-1:0]  r_nd106;

    assign w_sum = SUM_BITS'(i_dix) + SUM_BITS'(i_dual);
    assign w_m   = i_sh ? r_mag1[SUM_BITS-1:1] : r_mag1[MAG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= w_sum;
            r_mag1 <= w_sum[SUM_BITS-1] ? SUM_BITS'(-w_sum) : SUM_BITS'(w_sum);
            r_s2   <= r_s1;
            r_m2   <= w_m;
            r_sq2  <= SQ_BITS'(w_m) * SQ_BITS'(w_m);
        end
    end

    assign o_stat = '{big: |r_mag1[SUM_BITS-1:WORD_BITS-1], sq: r_sq2};

    sap_delay #(.WIDTH(SUM_BITS + MAG_BITS), .DEPTH(ROOT_BITS + 1)) u_dly_root (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_s2, r_m2}),
        .o_q   ({w_s35, w_m35})
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= NUM1_BITS'(i_rest) * NUM1_BITS'(w_m35) + NUM1_BITS'(i_root >> 1);
            r_n36 <= i_root;
            r_s36 <= w_s35;
        end
    end

    sap_div_pipe #(.QBITS(Q1_BITS), .DBITS(ROOT_BITS)) u_div_unit (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (ROOT_BITS'(r_num >> Q1_BITS)),
        .i_low (r_num[Q1_BITS-1:0]),
        .i_den (r_n36),
        .o_quo (w_q1),
        .o_rem ()
    );

    sap_delay #(.WIDTH(SUM_BITS + 1), .DEPTH(Q1_BITS)) u_dly_unit (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_s36, (r_n36 == '0)}),
        .o_q   ({w_s68, w_nz68})
    );

    assign w_pm   = w_nz68 ? '0 : w_q1;
    assign w_p    = w_s68[SUM_BITS-1] ? -$signed({2'b00, w_pm}) : $signed({2'b00, w_pm});
    assign w_diff = w_p - (ABSD_BITS+1)'(w_s68);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_absd   <= w_diff[ABSD_BITS] ? ABSD_BITS'(-w_diff) : ABSD_BITS'(w_diff);
            r_dneg69 <= w_diff[ABSD_BITS];
            r_s69    <= w_s68;
            r_prod   <= PROD_BITS'(i_stiff) * PROD_BITS'(r_absd);
            r_dneg70 <= r_dneg69;
            r_s70    <= r_s69;
        end
    end

    sap_div_pipe #(.QBITS(Q2_BITS), .DBITS(DEN_BITS)) u_div_blend (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (DEN_BITS'(r_prod >> (Q2_BITS - FRAC_BITS))),
        .i_low ({r_prod[Q2_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .i_den (i_den),
        .o_quo (w_q2),
        .o_rem (w_rem2)
    );

    sap_delay #(.WIDTH(SUM_BITS + 1), .DEPTH(Q2_BITS)) u_dly_blend (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_s70, r_dneg70}),
        .o_q   ({w_s104, w_dneg104})
    );

    assign w_up = {w_rem2, 1'b0} >= {1'b0, i_den};
    assign w_q  = (Q2_BITS+1)'(w_q2) + (Q2_BITS+1)'(w_up);
    assign w_z  = w_dneg104 ? Z_BITS'(w_s104) - $signed(Z_BITS'(w_q))
                            : Z_BITS'(w_s104) + $signed(Z_BITS'(w_q));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z105  <= (i_den == '0) ? '0 : sat_word(w_z);
            r_s105  <= w_s104;
            r_z106  <= r_z105;
            r_nd106 <= sat_word(Z_BITS'(r_s105) - Z_BITS'(r_z105));
        end
    end

    assign o_proj     = r_z106;
    assign o_new_dual = r_nd106;
endmodule

@@ rtl/spring_admm_projection.sv @@
// Top level: config registers, three component lanes, norm merge, output register and skid.
// Structure: 106 pipeline stages from input acceptance, then the output register.
// Throughput: one spring per cycle while not stalled; the square-root and divider pipelines take one bit per stage.
// The pipeline stalls only while the skid stage holds a word behind an unaccepted output.
// Reset (synchronous, active low) empties the pipeline and sets all three registers to 1.0.
module spring_admm_projection (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  sap_pkg::t_in_word                      i_in,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output sap_pkg::t_out_word                     o_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sap_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [sap_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import sap_pkg::*;

    logic [CFG_BITS-1:0]          r_rest;
    logic [CFG_BITS-1:0]          r_stiff;
    logic [CFG_BITS-1:0]          r_weight;
    logic [DEN_BITS-1:0]          r_den;
    logic                         w_en;
    logic signed [WORD_BITS-1:0]  w_dix      [LANES];
    logic signed [WORD_BITS-1:0]  w_dual     [LANES];
    logic signed [WORD_BITS-1:0]  w_proj     [LANES];
    logic signed [WORD_BITS-1:0]  w_new_dual [LANES];
    t_lane_stat                   w_stat     [LANES];
    logic                         w_sh;
    logic [SQ_BITS-1:0]           r_sumsq;
    logic [ROOT_BITS-1:0]         w_root;
    logic [LATENCY-1:0]           r_pipe_v;
    logic                         w_pipe_v;
    logic                         w_inc_v;
    t_out_word                    w_inc;
    logic                         r_out_v;
    logic                         r_skid_v;
    t_out_word                    r_out;
    t_out_word                    r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest   <= CFG_ONE;
            r_stiff  <= CFG_ONE;
            r_weight <= CFG_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REST:   r_rest   <= i_cfg_data[CFG_BITS-1:0];
                REG_STIFF:  r_stiff  <= i_cfg_data[CFG_BITS-1:0];
                REG_WEIGHT: r_weight <= i_cfg_data[CFG_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= DEN_BITS'(r_weight) * DEN_BITS'(r_weight) + (DEN_BITS'(r_stiff) << FRAC_BITS);
    end

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    assign w_dix[0]  = i_in.dix_x;
    assign w_dix[1]  = i_in.dix_y;
    assign w_dix[2]  = i_in.dix_z;
    assign w_dual[0] = i_in.dual_x;
    assign w_dual[1] = i_in.dual_y;
    assign w_dual[2] = i_in.dual_z;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        sap_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_dix      (w_dix[g]),
            .i_dual     (w_dual[g]),
            .i_sh       (w_sh),
            .i_root     (w_root),
            .i_rest     (r_rest),
            .i_stiff    (r_stiff),
            .i_den      (r_den),
            .o_stat     (w_stat[g]),
            .o_proj     (w_proj[g]),
            .o_new_dual (w_new_dual[g])
        );
    end

    assign w_sh = w_stat[0].big | w_stat[1].big | w_stat[2].big;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sumsq <= w_stat[0].sq + w_stat[1].sq + w_stat[2].sq;
        end
    end

    sap_sqrt_pipe #(.RBITS(ROOT_BITS)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sumsq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_v <= '0;
        end else if (w_en) begin
            r_pipe_v <= {r_pipe_v[LATENCY-2:0], i_valid};
        end
    end

    assign w_pipe_v = r_pipe_v[LATENCY-1];

    assign w_inc_v = w_en & w_pipe_v;
    assign w_inc   = '{proj_x:     w_proj[0],     proj_y:     w_proj[1],
                       proj_z:     w_proj[2],     new_dual_x: w_new_dual[0],
                       new_dual_y: w_new_dual[1], new_dual_z: w_new_dual[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_inc_v;
            end
        end else if (w_inc_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : w_inc;
        end
        if (r_out_v && !i_ready && w_inc_v) begin
            r_skid <= w_inc;
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with no output word");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> (r_out_v && !r_skid_v))
        else $error("skid word not moved to output after take");

    a_cfg_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_REST) |=>
        (r_rest == $past(i_cfg_data[CFG_BITS-1:0])))
        else $error("rest length write lost");
endmodule

@@ tb/spring_admm_projection_tb.sv @@
// Testbench for the spring projection block: directed and random springs over several register settings.
`timescale 1ns / 1ps

module spring_admm_projection_tb;
    import sap_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = LATENCY + 20;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    t_in_word                  i_in;
    logic                      o_valid;
    logic                      i_ready;
    t_out_word                 o_out;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    longint unsigned rest_len_q;
    longint unsigned stiff_q;
    longint unsigned weight_q;

    t_out_word pending_blends[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        burst_left = 0;
    int        stall_mode = 0;

    spring_admm_projection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] clamp_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[WORD_BITS-1:0];
    endfunction

    function automatic t_out_word spring_blend(t_in_word w);
        longint          dx[3], du[3], sv[3], pv[3], diff;
        longint unsigned m[3], sumsq, root, den, pm, ad;
        logic [127:0]    prod, q;
        logic signed [WORD_BITS-1:0] zv[3], uv[3];
        bit              sh;
        t_out_word       r;
        dx[0] = w.dix_x;  dx[1] = w.dix_y;  dx[2] = w.dix_z;
        du[0] = w.dual_x; du[1] = w.dual_y; du[2] = w.dual_z;
        sh = 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            sv[i] = dx[i] + du[i];
            m[i] = sv[i] < 0 ? -sv[i] : sv[i];
            if (m[i] >= 64'd2147483648) sh = 1;
        end
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sumsq += m[i] * m[i];
        end
        root = root_floor(sumsq);
        for (int i = 0; i < 3; i++) begin
            pm = (root == 0) ? 0 : (rest_len_q * m[i] + (root >> 1)) / root;
            pv[i] = sv[i] < 0 ? -longint'(pm) : longint'(pm);
        end
        den = weight_q * weight_q + (stiff_q << FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            if (den == 0) begin
                zv[i] = '0;
            end else begin
                diff = pv[i] - sv[i];
                ad = diff < 0 ? -diff : diff;
                prod = 128'(stiff_q << FRAC_BITS) * 128'(ad);
                q = (2 * prod + 128'(den)) / (2 * 128'(den));
                zv[i] = clamp_word(diff < 0 ? sv[i] - longint'(q) : sv[i] + longint'(q));
            end
            uv[i] = clamp_word(du[i] + dx[i] - longint'(zv[i]));
        end
        r.proj_x = zv[0]; r.proj_y = zv[1]; r.proj_z = zv[2];
        r.new_dual_x = uv[0]; r.new_dual_y = uv[1]; r.new_dual_z = uv[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** spring_admm_projection: FAILED **");
            $finish;
        end
    end

    // receiver: rotate through always-ready, random and periodic stalls
    always @(posedge i_clk) begin
        t_out_word want;
        string     tag[6];
        tag = '{"proj_x", "proj_y", "proj_z", "new_dual_x", "new_dual_y", "new_dual_z"};
        if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 9) < 6);
            default: i_ready <= ((cycles % 7) < 3);
        endcase
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_blends.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_out);
            end else begin
                want = pending_blends.pop_front();
                for (int f = 0; f < 6; f++) begin
                    if (o_out[191 - 32*f -: 32] !== want[191 - 32*f -: 32]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s: expected %h got %h", tag[f],
                                     want[191 - 32*f -: 32], o_out[191 - 32*f -: 32]);
                    end
                end
            end
        end
    end

    task automatic send_spring(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (!o_ready);
        pending_blends.insert(pending_blends.size(), spring_blend(w));
        burst_left--;
    endtask

    task automatic drain_blends();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_blends.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_REST:   rest_len_q = data[CFG_BITS-1:0];
            REG_STIFF:  stiff_q = data[CFG_BITS-1:0];
            REG_WEIGHT: weight_q = data[CFG_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp(int kind);
        case (kind)
            0: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
            default: return 32'($urandom_range(0, 32'h7FF)) - 32'h400;
        endcase
    endfunction

    function automatic t_in_word rand_spring();
        t_in_word w;
        int       kind;
        kind = $urandom_range(0, 9);
        kind = kind < 5 ? 0 : kind < 8 ? 1 : kind < 9 ? 2 : 3;
        w = {rand_comp(kind), rand_comp(kind), rand_comp(kind),
             rand_comp(kind), rand_comp(kind), rand_comp(kind)};
        if ($urandom_range(0, 19) == 0) begin
            w.dual_x = -w.dix_x; w.dual_y = -w.dix_y; w.dual_z = -w.dix_z;
        end
        return w;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_spring(rand_spring());
        drain_blends();
    endtask

    task automatic test_directed();
        t_in_word set[$];
        set.insert(set.size(), '0);
        set.insert(set.size(), {32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        set.insert(set.size(), {32'h0, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 32'h0});
        set.insert(set.size(), {32'h0, 32'h0, 32'h00030000, 32'h0, 32'h0, 32'h00010000});
        set.insert(set.size(), {32'h00012345, 32'hFFFE0000, 32'h00008000,
                                32'hFFFEDCBB, 32'h00020000, 32'hFFFF8000});
        set.insert(set.size(), {6{32'h7FFFFFFF}});
        set.insert(set.size(), {6{32'h80000000}});
        set.insert(set.size(), {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        set.insert(set.size(), {32'h7FFFFFFF, 32'h0, 32'h0, 32'h00000001, 32'h0, 32'h0});
        set.insert(set.size(), {32'h80000000, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0});
        set.insert(set.size(), {32'h40000000, 32'h40000000, 32'h40000000, 32'h0, 32'h0, 32'h0});
        set.insert(set.size(), {32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        set.insert(set.size(), {32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0, 32'h0});
        set.insert(set.size(), {32'h00050000, 32'h0, 32'h0, 32'hFFFB0000, 32'h0, 32'h0});
        foreach (set[i]) send_spring(set[i]);
        drain_blends();
    endtask

    task automatic test_defaults();
        run_random(300);
    endtask

    task automatic test_zero_rest();
        write_reg(REG_REST, 32'h0);
        test_directed();
        run_random(200);
    endtask

    task automatic test_zero_denominator();
        write_reg(REG_STIFF, 32'h0);
        write_reg(REG_WEIGHT, 32'h0);
        test_directed();
        run_random(150);
        write_reg(REG_WEIGHT, 32'h00008000);
        run_random(150);
    endtask

    task automatic test_full_scale();
        write_reg(REG_REST, 32'hFFFFFFFF);
        write_reg(REG_STIFF, 32'h7FFFFFFF);
        write_reg(REG_WEIGHT, 32'h7FFFFFFF);
        test_directed();
        run_random(200);
        write_reg(REG_WEIGHT, 32'h0);
        run_random(150);
    endtask

    task automatic test_ignored_index();
        write_reg(REG_SPARE, $urandom());
        run_random(50);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            write_reg(REG_REST, $urandom());
            write_reg(REG_STIFF, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h40000));
            write_reg(REG_WEIGHT, $urandom_range(0, 1) ? $urandom()
                                                       : $urandom_range(0, 32'h40000));
            run_random(100);
        end
    endtask

    initial begin
        rest_len_q = CFG_ONE;
        stiff_q = CFG_ONE;
        weight_q = CFG_ONE;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        i_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_REST;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_defaults();
        test_zero_rest();
        test_zero_denominator();
        test_full_scale();
        test_ignored_index();
        test_random_settings();
        drain_blends();

        if (mismatches == 0 && pending_blends.size() == 0) begin
            $display("** spring_admm_projection: PASSED **");
        end else begin
            $display("** spring_admm_projection: FAILED **");
        end
        $finish;
    end

endmodule
